// ===== rtl/core/tun_pkg.sv =====
`default_nettype none
package tun_pkg;

  localparam int RES_MAX = 5;
  localparam int RES_IW  = $clog2(RES_MAX);
  localparam int RES_CW  = $clog2(RES_MAX + 1);
  localparam int FEED_MAX = 3;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_COLON      = 8'h3A;
  localparam logic [7:0] CH_PERCENT    = 8'h25;
  localparam logic [7:0] CH_TWO        = 8'h32;
  localparam logic [7:0] CH_ZERO       = 8'h30;

  localparam logic [1:0] HELD_NONE = 2'd0;
  localparam logic [1:0] HELD_PCT  = 2'd1;
  localparam logic [1:0] HELD_PCT2 = 2'd2;

  typedef struct packed {
    logic [1:0] held;
    logic       pend;
    logic       text;
    logic       colon;
    logic       chg;
  } tun_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
    logic       chg;
  } tun_res_t;

  typedef struct packed {
    tun_state_t st;
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
  } tun_s2_t;

  // Underscore cleaning of one character around the first colon.
  function automatic tun_s2_t stage_two(tun_state_t s, logic [7:0] c);
    tun_s2_t r;
    r.st  = s;
    r.cnt = 2'd0;
    r.b0  = c;
    r.b1  = c;
    if (c == CH_UNDERSCORE) begin
      if (!s.text || s.pend) begin
        r.st.chg = 1'b1;
      end else begin
        r.st.pend = 1'b1;
      end
    end else if (c == CH_COLON && !s.colon) begin
      if (s.pend) begin
        r.st.chg = 1'b1;
      end
      r.st.pend  = 1'b0;
      r.st.text  = 1'b0;
      r.st.colon = 1'b1;
      r.cnt      = 2'd1;
    end else begin
      if (s.pend) begin
        r.cnt = 2'd2;
        r.b0  = CH_UNDERSCORE;
      end else begin
        r.cnt = 2'd1;
      end
      r.st.pend = 1'b0;
      r.st.text = 1'b1;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/tun_step.sv =====
`default_nettype none
module tun_step (
  input  tun_pkg::tun_state_t                    st,
  input  logic [7:0]                             byte_i,
  input  logic                                   last_i,
  output tun_pkg::tun_state_t                    st_nxt,
  output tun_pkg::tun_res_t [tun_pkg::RES_MAX-1:0] res,
  output logic [tun_pkg::RES_CW-1:0]             res_cnt
);

  function automatic logic [tun_pkg::RES_CW-1:0] RES_CW_MAX();
    return tun_pkg::RES_CW'(tun_pkg::RES_MAX);
  endfunction

  always_comb begin
    logic [7:0]                    feed [tun_pkg::FEED_MAX];
    logic [tun_pkg::FEED_MAX-1:0]  fv;
    logic [1:0]                    held;
    tun_pkg::tun_state_t           s;
    tun_pkg::tun_s2_t              r;
    logic [tun_pkg::RES_CW-1:0]    n;

    s    = st;
    fv   = '0;
    held = tun_pkg::HELD_NONE;
    n    = '0;
    res  = '0;
    for (int i = 0; i < tun_pkg::FEED_MAX; i++) begin
      feed[i] = byte_i;
    end

    case (st.held)
      tun_pkg::HELD_PCT: begin
        if (byte_i == tun_pkg::CH_TWO) begin
          held = tun_pkg::HELD_PCT2;
        end else if (byte_i == tun_pkg::CH_PERCENT) begin
          feed[0] = tun_pkg::CH_PERCENT;
          fv      = 3'b001;
          held    = tun_pkg::HELD_PCT;
        end else begin
          feed[0] = tun_pkg::CH_PERCENT;
          feed[1] = byte_i;
          fv      = 3'b011;
        end
      end
      tun_pkg::HELD_PCT2: begin
        if (byte_i == tun_pkg::CH_ZERO) begin
          s.chg   = 1'b1;
          feed[0] = tun_pkg::CH_UNDERSCORE;
          fv      = 3'b001;
        end else if (byte_i == tun_pkg::CH_PERCENT) begin
          feed[0] = tun_pkg::CH_PERCENT;
          feed[1] = tun_pkg::CH_TWO;
          fv      = 3'b011;
          held    = tun_pkg::HELD_PCT;
        end else begin
          feed[0] = tun_pkg::CH_PERCENT;
          feed[1] = tun_pkg::CH_TWO;
          feed[2] = byte_i;
          fv      = 3'b111;
        end
      end
      default: begin
        if (byte_i == tun_pkg::CH_PERCENT) begin
          held = tun_pkg::HELD_PCT;
        end else begin
          feed[0] = byte_i;
          fv      = 3'b001;
        end
      end
    endcase

    // A partial match left over on the last byte is released as text.
    if (last_i) begin
      if (held == tun_pkg::HELD_PCT) begin
        if (fv[1]) begin
          feed[2] = tun_pkg::CH_PERCENT;
          fv      = 3'b111;
        end else if (fv[0]) begin
          feed[1] = tun_pkg::CH_PERCENT;
          fv      = 3'b011;
        end else begin
          feed[0] = tun_pkg::CH_PERCENT;
          fv      = 3'b001;
        end
      end else if (held == tun_pkg::HELD_PCT2) begin
        feed[0] = tun_pkg::CH_PERCENT;
        feed[1] = tun_pkg::CH_TWO;
        fv      = 3'b011;
      end
    end

    for (int i = 0; i < tun_pkg::FEED_MAX; i++) begin
      r = tun_pkg::stage_two(s, feed[i]);
      if (fv[i]) begin
        s = r.st;
        if (r.cnt != 2'd0 && n < RES_CW_MAX()) begin
          res[n[tun_pkg::RES_IW-1:0]] = '{data: r.b0, is_end: 1'b0, chg: 1'b0};
          n = n + 1'b1;
        end
        if (r.cnt == 2'd2 && n < RES_CW_MAX()) begin
          res[n[tun_pkg::RES_IW-1:0]] = '{data: r.b1, is_end: 1'b0, chg: 1'b0};
          n = n + 1'b1;
        end
      end
    end

    if (last_i) begin
      if (s.pend) begin
        s.chg = 1'b1;
      end
      if (n < RES_CW_MAX()) begin
        res[n[tun_pkg::RES_IW-1:0]] = '{data: 8'h00, is_end: 1'b1, chg: s.chg};
        n = n + 1'b1;
      end
      st_nxt = '0;
    end else begin
      st_nxt      = s;
      st_nxt.held = held;
    end
    res_cnt = n;
  end

endmodule
`default_nettype wire

// ===== rtl/core/tun_outbuf.sv =====
`default_nettype none
module tun_outbuf (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   load,
  input  tun_pkg::tun_res_t [tun_pkg::RES_MAX-1:0] res,
  input  logic [tun_pkg::RES_CW-1:0]             res_cnt,
  input  logic                                   out_ready,
  output logic                                   out_valid,
  output logic [7:0]                             out_byte,
  output logic                                   out_has_byte,
  output logic                                   out_is_end,
  output logic                                   out_was_changed,
  output logic                                   buf_free
);

  tun_pkg::tun_res_t [tun_pkg::RES_MAX-1:0] ent_r;
  logic [tun_pkg::RES_CW-1:0]               n_r, n_nxt;
  logic [tun_pkg::RES_CW-1:0]               rd_r, rd_nxt;
  logic [tun_pkg::RES_CW-1:0]               left;
  tun_pkg::tun_res_t                        cur;

  assign left      = n_r - rd_r;
  assign out_valid = (left != '0);
  assign buf_free  = (left == '0) || ((left == tun_pkg::RES_CW'(1)) && out_ready);

  always_comb begin
    if (rd_r < tun_pkg::RES_CW'(tun_pkg::RES_MAX)) begin
      cur = ent_r[rd_r[tun_pkg::RES_IW-1:0]];
    end else begin
      cur = '0;
    end
  end

  assign out_byte        = cur.data;
  assign out_has_byte    = !cur.is_end;
  assign out_is_end      = cur.is_end;
  assign out_was_changed = cur.chg;

  always_comb begin
    n_nxt  = n_r;
    rd_nxt = rd_r;
    if (load) begin
      n_nxt  = res_cnt;
      rd_nxt = '0;
    end else if (out_valid && out_ready) begin
      rd_nxt = rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r  <= '0;
      rd_r <= '0;
    end else begin
      n_r  <= n_nxt;
      rd_r <= rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= res;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/title_underscore_normalizer_core.sv =====
// Title underscore normalizer.
// The input channel (in_valid/in_ready) takes one byte of a page-title
// segment per request, with in_last on its final byte. The result channel
// (out_valid/out_ready) gives cleaned bytes with out_has_byte set, and after
// the final byte one end request with out_is_end set and out_was_changed
// telling whether any "%20" was replaced or any underscore dropped.
// A request is held in an input register, cleaned combinationally, and its
// results (zero to five) are written into a small result buffer once the
// buffer is free. The first result of a request is offered from the result
// buffer after the request has passed the input register and been loaded.
// A request with at most one result lets a new request enter every cycle
// while the receiver is ready; a request with more results occupies the
// result buffer, and the input side waits while the buffer drains.
// When the receiver stalls, the buffer holds its current result and the
// input register fills, after which in_ready drops.
// Reset empties both registers and returns the cleaning state to the start
// of a segment; the state also returns there after every end request.
`default_nettype none
module title_underscore_normalizer_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_is_end,
  output logic       out_was_changed
);

  logic                                   inq_valid_r;
  logic [7:0]                             inq_byte_r;
  logic                                   inq_last_r;
  tun_pkg::tun_state_t                    st_r;
  tun_pkg::tun_state_t                    st_nxt;
  tun_pkg::tun_res_t [tun_pkg::RES_MAX-1:0] res;
  logic [tun_pkg::RES_CW-1:0]             res_cnt;
  logic                                   buf_free;
  logic                                   load;

  assign load     = inq_valid_r && buf_free;
  assign in_ready = !inq_valid_r || load;

  tun_step u_step (
    .st      (st_r),
    .byte_i  (inq_byte_r),
    .last_i  (inq_last_r),
    .st_nxt  (st_nxt),
    .res     (res),
    .res_cnt (res_cnt)
  );

  tun_outbuf u_outbuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .load            (load),
    .res             (res),
    .res_cnt         (res_cnt),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_byte        (out_byte),
    .out_has_byte    (out_has_byte),
    .out_is_end      (out_is_end),
    .out_was_changed (out_was_changed),
    .buf_free        (buf_free)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inq_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_ready) begin
        inq_valid_r <= in_valid;
      end
      if (load) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inq_byte_r <= in_byte;
      inq_last_r <= in_last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/tun_checker.sv =====
`default_nettype none
module tun_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_byte,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_has_byte,
  input logic       out_is_end,
  input logic       out_was_changed
);

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result offered right after reset");

  // A request shows either a byte or the end marker, never both.
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_has_byte != out_is_end))
    else $error("result kind inconsistent");

  // Only the end request reports a change.
  a_chg_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_end) |-> !out_was_changed)
    else $error("change flag on a byte result");

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_byte) && $stable(out_is_end)
       && $stable(out_was_changed)))
    else $error("stalled result changed");

  // A waiting input request keeps its payload until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_ready) |=>
      (in_valid && $stable(in_byte) && $stable(in_last)))
    else $error("waiting input request changed");

endmodule

bind title_underscore_normalizer_core tun_checker u_tun_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_byte         (in_byte),
  .in_last         (in_last),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_has_byte    (out_has_byte),
  .out_is_end      (out_is_end),
  .out_was_changed (out_was_changed)
);
`default_nettype wire
